>>> rtl/core/rti_pkg.sv
// Shared widths, types and register codes for the ray/triangle intersection pipeline.
package rti_pkg;

  localparam int CW   = 33;          // coordinate difference width (edges, tvec)
  localparam int PW   = 2 * CW;      // one cross product term
  localparam int XW   = PW + 1;      // cross product component
  localparam int LW   = 32;          // low slice of a cross component
  localparam int HW   = XW - LW;     // high slice of a cross component
  localparam int MW   = XW + CW;     // one dot product term
  localparam int DW   = MW + 2;      // dot product sum
  localparam int QW   = 33;          // quotient bits per divider
  localparam int FRAC = 16;          // Q16.16 fraction bits
  localparam int OVS  = QW - FRAC;   // numerator shift that seeds the divider

  typedef logic signed [CW-1:0] crd_t;
  typedef logic signed [XW-1:0] xpr_t;
  typedef logic signed [DW-1:0] dsum_t;

  typedef struct packed {
    logic hit;
    logic ovf;
    logic tneg;
  } tflag_t;

  typedef enum logic [2:0] {
    REG_ORG_X = 3'd0,
    REG_ORG_Y = 3'd1,
    REG_ORG_Z = 3'd2,
    REG_DIR_X = 3'd3,
    REG_DIR_Y = 3'd4,
    REG_DIR_Z = 3'd5,
    REG_EPS   = 3'd6
  } cfg_reg_t;

endpackage

>>> rtl/core/rti_cross.sv
// Two-stage cross product of two 33-bit signed vectors.
module rti_cross (
  input  logic           clk,
  input  logic           en,
  input  rti_pkg::crd_t  a [3],
  input  rti_pkg::crd_t  b [3],
  output rti_pkg::xpr_t  c [3]
);
  import rti_pkg::*;

  logic signed [PW-1:0] m_r [6];
  xpr_t                 c_r [3];

  // products of the three 2x2 minors
  always_ff @(posedge clk) begin
    if (en) begin
      m_r[0] <= a[1] * b[2];
      m_r[1] <= a[2] * b[1];
      m_r[2] <= a[2] * b[0];
      m_r[3] <= a[0] * b[2];
      m_r[4] <= a[0] * b[1];
      m_r[5] <= a[1] * b[0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        c_r[i] <= XW'(m_r[2*i]) - XW'(m_r[2*i+1]);
      end
    end
  end

  assign c = c_r;

endmodule

>>> rtl/core/rti_dot.sv
// Three-stage dot product of a cross vector with a coordinate vector.
module rti_dot (
  input  logic           clk,
  input  logic           en,
  input  rti_pkg::xpr_t  c [3],
  input  rti_pkg::crd_t  w [3],
  output rti_pkg::dsum_t s
);
  import rti_pkg::*;

  logic signed [LW+CW:0]   plo_r [3];
  logic signed [HW+CW-1:0] phi_r [3];
  logic signed [MW-1:0]    prd_r [3];
  dsum_t                   s_r;

  // split each cross component into a low unsigned and a high signed slice
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        plo_r[i] <= $signed({1'b0, c[i][LW-1:0]}) * w[i];
        phi_r[i] <= $signed(c[i][XW-1:LW]) * w[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        prd_r[i] <= $signed({phi_r[i], {LW{1'b0}}}) + MW'(plo_r[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r <= DW'(prd_r[0]) + DW'(prd_r[1]) + DW'(prd_r[2]);
    end
  end

  assign s = s_r;

endmodule

>>> rtl/core/rti_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module rti_div #(
  parameter int QN = 33,
  parameter int RW = 102
) (
  input  logic          clk,
  input  logic          en,
  input  logic [RW-1:0] r0,
  input  logic [QN-1:0] nlo,
  input  logic [RW-1:0] d,
  output logic [QN-1:0] q
);

  logic [RW-1:0] r_r  [QN];
  logic [RW-1:0] d_r  [QN];
  logic [QN-1:0] lo_r [QN];
  logic [QN-1:0] q_r  [QN];

  for (genvar k = 0; k < QN; k++) begin : g_stg
    logic [RW-1:0] rin;
    logic [RW-1:0] din;
    logic [QN-1:0] loin;
    logic [QN-1:0] qin;
    logic [RW:0]   tr;
    logic          ge;

    if (k == 0) begin : g_first
      assign rin  = r0;
      assign din  = d;
      assign loin = nlo;
      assign qin  = '0;
    end else begin : g_next
      assign rin  = r_r[k-1];
      assign din  = d_r[k-1];
      assign loin = lo_r[k-1];
      assign qin  = q_r[k-1];
    end

    // shift in the next numerator bit, subtract when the divisor fits
    assign tr = {rin, loin[QN-1]};
    assign ge = tr >= {1'b0, din};

    always_ff @(posedge clk) begin
      if (en) begin
        r_r[k]  <= ge ? RW'(tr - {1'b0, din}) : tr[RW-1:0];
        d_r[k]  <= din;
        lo_r[k] <= {loin[QN-2:0], 1'b0};
        q_r[k]  <= {qin[QN-2:0], ge};
      end
    end
  end

  assign q = q_r[QN-1];

endmodule

>>> rtl/core/ray_triangle_intersect.sv
// Top level: double-sided ray/triangle intersection, one triangle per beat.
//
//  channel  dir  beat contents (low bit first)
//  in_      in   tdata: vert0_x, vert0_y, vert0_z, vert1_x .. vert2_z (9 x 32)
//  out_     out  tdata: hit_distance, bary_u, bary_v, 6 zero bits; tuser: hit
//  cfg_     in   write of one ray register: origin xyz, dir xyz, det_epsilon
//
// One triangle enters per cycle while out_ is not stalled; each result passes ten arithmetic
// stages, then the 33-stage quotient pipeline and the output register.
// rst_n (synchronous) empties the pipeline and loads the ray register defaults.
// A stall on out_ freezes every stage at once; bubbles stay in place.
module ray_triangle_intersect (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [287:0] in_tdata,   // vert0_x, vert0_y, vert0_z, vert1_x..z, vert2_x..z
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [71:0]  out_tdata,  // hit_distance[31:0], bary_u[48:32], bary_v[65:49]
  output logic         out_tuser,  // hit
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [31:0]  cfg_wdata
);
  import rti_pkg::*;

  localparam int PRE  = 10;
  localparam int NSTG = PRE + QW;

  // ray registers
  logic signed [31:0] org_r [3];
  logic signed [31:0] dir_r [3];
  logic [15:0]        eps_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_r[0] <= '0;
      org_r[1] <= '0;
      org_r[2] <= '0;
      dir_r[0] <= '0;
      dir_r[1] <= '0;
      dir_r[2] <= 32'sd65536;
      eps_r    <= 16'd7;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_ORG_X: org_r[0] <= cfg_wdata;
        REG_ORG_Y: org_r[1] <= cfg_wdata;
        REG_ORG_Z: org_r[2] <= cfg_wdata;
        REG_DIR_X: dir_r[0] <= cfg_wdata;
        REG_DIR_Y: dir_r[1] <= cfg_wdata;
        REG_DIR_Z: dir_r[2] <= cfg_wdata;
        REG_EPS:   eps_r    <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // global advance: move when the output slot is free or being taken
  logic en;
  logic out_tvalid_r;
  logic [NSTG-1:0] vld_r;

  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      vld_r        <= {vld_r[NSTG-2:0], in_tvalid};
      out_tvalid_r <= vld_r[NSTG-1];
    end
  end

  // stage 1: edges and origin offset
  crd_t dir33 [3];
  crd_t s1_e1_r [3], s1_e2_r [3], s1_tp_r [3];
  crd_t s2_e1_r [3], s2_e2_r [3], s2_tp_r [3];
  crd_t s3_e1_r [3], s3_e2_r [3], s3_tp_r [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dir33[i] = CW'(dir_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_e1_r[i] <= CW'($signed(in_tdata[96+32*i +: 32]))
                    - CW'($signed(in_tdata[32*i +: 32]));
        s1_e2_r[i] <= CW'($signed(in_tdata[192+32*i +: 32]))
                    - CW'($signed(in_tdata[32*i +: 32]));
        s1_tp_r[i] <= CW'(org_r[i]) - CW'($signed(in_tdata[32*i +: 32]));
        s2_e1_r[i] <= s1_e1_r[i];
        s2_e2_r[i] <= s1_e2_r[i];
        s2_tp_r[i] <= s1_tp_r[i];
        s3_e1_r[i] <= s2_e1_r[i];
        s3_e2_r[i] <= s2_e2_r[i];
        s3_tp_r[i] <= s2_tp_r[i];
      end
    end
  end

  // stages 2-3: pvec = dir x edge2, qvec taken with tvec before the sign flip
  xpr_t pvec [3];
  xpr_t qvec [3];

  rti_cross u_pcross (.clk(clk), .en(en), .a(dir33),   .b(s1_e2_r), .c(pvec));
  rti_cross u_qcross (.clk(clk), .en(en), .a(s1_tp_r), .b(s1_e1_r), .c(qvec));

  // stages 4-6: the four dot products
  dsum_t det_d, u_d, v_d, t_d;

  rti_dot u_ddet (.clk(clk), .en(en), .c(pvec), .w(s3_e1_r), .s(det_d));
  rti_dot u_du   (.clk(clk), .en(en), .c(pvec), .w(s3_tp_r), .s(u_d));
  rti_dot u_dv   (.clk(clk), .en(en), .c(qvec), .w(dir33),   .s(v_d));
  rti_dot u_dt   (.clk(clk), .en(en), .c(qvec), .w(s3_e2_r), .s(t_d));

  // stage 7: u + v before the sign fix
  dsum_t              det7_r, u7_r, v7_r, t7_r;
  logic signed [DW:0] uv7_r;

  always_ff @(posedge clk) begin
    if (en) begin
      det7_r <= det_d;
      u7_r   <= u_d;
      v7_r   <= v_d;
      t7_r   <= t_d;
      uv7_r  <= (DW+1)'(u_d) + (DW+1)'(v_d);
    end
  end

  // stage 8: flip everything when det is not positive
  logic               pos7;
  dsum_t              adet8_r, u8_r, v8_r, t8_r;
  logic signed [DW:0] uv8_r;

  assign pos7 = !det7_r[DW-1] && (det7_r != '0);

  always_ff @(posedge clk) begin
    if (en) begin
      adet8_r <= pos7 ? det7_r : -det7_r;
      u8_r    <= pos7 ? u7_r   : -u7_r;
      v8_r    <= pos7 ? v7_r   : -v7_r;
      t8_r    <= pos7 ? t7_r   : -t7_r;
      uv8_r   <= pos7 ? uv7_r  : -uv7_r;
    end
  end

  // stage 9: hit test, magnitude of t
  logic          miss8;
  logic          hit9_r, tneg9_r;
  logic [DW-1:0] adet9_r, u9_r, v9_r, tmag9_r;

  always_comb begin
    miss8 = (adet8_r == '0)
         || ($unsigned(adet8_r) < DW'({eps_r, 32'b0}))
         || u8_r[DW-1]
         || (u8_r > adet8_r)
         || v8_r[DW-1]
         || (uv8_r > (DW+1)'(adet8_r));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit9_r  <= !miss8;
      tneg9_r <= t8_r[DW-1];
      tmag9_r <= t8_r[DW-1] ? $unsigned(-t8_r) : $unsigned(t8_r);
      adet9_r <= adet8_r;
      u9_r    <= u8_r;
      v9_r    <= v8_r;
    end
  end

  // stage 10: flag a t quotient beyond the divider's reach
  tflag_t        fl10_r;
  logic [DW-1:0] adet10_r, u10_r, v10_r, tmag10_r;

  always_ff @(posedge clk) begin
    if (en) begin
      fl10_r.hit  <= hit9_r;
      fl10_r.tneg <= tneg9_r;
      fl10_r.ovf  <= {{OVS{1'b0}}, tmag9_r} >= {adet9_r, {OVS{1'b0}}};
      adet10_r    <= adet9_r;
      u10_r       <= u9_r;
      v10_r       <= v9_r;
      tmag10_r    <= tmag9_r;
    end
  end

  // stages 11-43: (x << 16) / det, seeded with x >> 17
  logic [QW-1:0] qt, qu, qv;
  tflag_t        fl_r [QW];

  rti_div #(.QN(QW), .RW(DW)) u_divt (
    .clk(clk), .en(en), .r0(DW'(tmag10_r >> OVS)),
    .nlo({tmag10_r[OVS-1:0], {FRAC{1'b0}}}), .d(adet10_r), .q(qt));
  rti_div #(.QN(QW), .RW(DW)) u_divu (
    .clk(clk), .en(en), .r0(DW'(u10_r >> OVS)),
    .nlo({u10_r[OVS-1:0], {FRAC{1'b0}}}), .d(adet10_r), .q(qu));
  rti_div #(.QN(QW), .RW(DW)) u_divv (
    .clk(clk), .en(en), .r0(DW'(v10_r >> OVS)),
    .nlo({v10_r[OVS-1:0], {FRAC{1'b0}}}), .d(adet10_r), .q(qv));

  always_ff @(posedge clk) begin
    if (en) begin
      fl_r[0] <= fl10_r;
      for (int k = 1; k < QW; k++) begin
        fl_r[k] <= fl_r[k-1];
      end
    end
  end

  // output register: saturate t, zero everything on a miss
  tflag_t      flo;
  logic [31:0] t_sat;
  logic [71:0] out_tdata_r;
  logic        out_tuser_r;

  assign flo = fl_r[QW-1];

  always_comb begin
    if (flo.tneg) begin
      if (flo.ovf || (qt > 33'h080000000)) t_sat = 32'h80000000;
      else                                 t_sat = -qt[31:0];
    end else begin
      if (flo.ovf || (qt > 33'h07FFFFFFF)) t_sat = 32'h7FFFFFFF;
      else                                 t_sat = qt[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tuser_r <= flo.hit;
      out_tdata_r <= flo.hit ? {6'b0, qv[16:0], qu[16:0], t_sat} : '0;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("miss result carries nonzero data");

  a_bary_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[48:32] <= 17'h10000) && (out_tdata[65:49] <= 17'h10000))
    else $error("barycentric coordinate above one");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    en && vld_r[NSTG-1] |=> out_tvalid)
    else $error("pipeline result dropped at output");

endmodule
